FILE: src/c3sd_pkg.sv
// Package for the CR3BP state derivative core: fixed constants of the datapath.
// No dependencies; imported by the top level.
package c3sd_pkg;
    localparam int MU_BITS  = 27;                       // width of the mass ratio register
    localparam int CAP_BITS = 12;                       // gravity term cap exponent above FRAC
    localparam logic [MU_BITS-1:0] MU_RESET = 27'd1630760;
endpackage

FILE: src/c3sd_isqrt.sv
// Pipelined integer square root, one root bit per stage.
// Standalone; used by cr3bp_state_derivative_core.
module c3sd_isqrt #(
    parameter int RB = 34              // root bits; radicand has 2*RB bits
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*RB-1:0]   i_rad,
    output logic [RB-1:0]     o_root
);
    localparam int SB = 2 * RB;
    localparam int RW = RB + 3;

    logic [RW-1:0] r_rem  [RB];
    logic [RB-1:0] r_root [RB];
    logic [SB-1:0] r_rad  [RB];

    genvar j;
    generate
        for (j = 0; j < RB; j++) begin : g_stage
            logic [RW-1:0] rem_in, cur, trial;
            logic [RB-1:0] root_in;
            logic [SB-1:0] rad_in;
            logic          ge;
            if (j == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = i_rad;
            end else begin : g_next
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
                assign rad_in  = r_rad[j-1];
            end
            // bring in two radicand bits, try root*4+1
            assign cur   = {rem_in[RW-3:0], rad_in[SB-1 -: 2]};
            assign trial = RW'({root_in, 2'b01});
            assign ge    = (cur >= trial);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= ge ? cur - trial : cur;
                    r_root[j] <= {root_in[RB-2:0], ge};
                    r_rad[j]  <= {rad_in[SB-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[RB-1];
endmodule

FILE: src/c3sd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by cr3bp_state_derivative_core.
module c3sd_div #(
    parameter int DW = 34,             // divisor and remainder bits
    parameter int QW = 28              // quotient bits
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,       // leading part of the dividend, below i_den
    input  logic [QW-1:0] i_bits,      // remaining dividend bits, msb first
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [QW-1:0] r_quo  [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            logic [DW-1:0] rem_in, den_in;
            logic [QW-1:0] bits_in, quo_in;
            logic [DW:0]   cur;
            logic          ge;
            if (j == 0) begin : g_first
                assign rem_in  = i_rem;
                assign den_in  = i_den;
                assign bits_in = i_bits;
                assign quo_in  = '0;
            end else begin : g_next
                assign rem_in  = r_rem[j-1];
                assign den_in  = r_den[j-1];
                assign bits_in = r_bits[j-1];
                assign quo_in  = r_quo[j-1];
            end
            // shift in next dividend bit, subtract if it fits
            assign cur = {rem_in, bits_in[QW-1]};
            assign ge  = (cur >= {1'b0, den_in});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= DW'(ge ? cur - {1'b0, den_in} : cur);
                    r_den[j]  <= den_in;
                    r_bits[j] <= {bits_in[QW-2:0], 1'b0};
                    r_quo[j]  <= {quo_in[QW-2:0], ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];
endmodule

FILE: src/cr3bp_state_derivative_core.sv
// CR3BP state derivative: rotating-frame state in, velocity and acceleration out.
// Depends on c3sd_pkg, c3sd_isqrt and c3sd_div.
//
//  channel  | ports           | payload
//  ---------+-----------------+------------------------------------------------
//  state in | s_axis_*        | tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
//  deriv out| m_axis_*        | tdata: rate_x..z, accel_x..z; tuser: saturated
//  config   | cfg_wr_*        | mass ratio mu, Q0.27
//
// One word per cycle in and out while no word is parked in the skid register. Latency is
// set by the square root (one bit per stage) and the two divider chains.
// Reset clears valid bits, the output register, the skid word and loads the default mu.
// A stalled output parks one word in a skid register; the pipeline then holds
// all stages until it drains, so nothing is dropped or repeated.
module cr3bp_state_derivative_core
    import c3sd_pkg::*;
#(
    parameter int FRAC_BITS = 27,
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (lowest first), zero padded
    input  logic [((6 * WORD_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z (lowest first), zero padded
    output logic [((6 * WORD_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // saturated
    output logic                   o_m_axis_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [MU_BITS-1:0]     i_cfg_wr_data
);
    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int TDW  = ((6 * W + 7) / 8) * 8;
    localparam int MX0  = (W > F + 1) ? W : F + 1;
    localparam int DXW  = ((MX0 > MU_BITS + 1) ? MX0 : MU_BITS + 1) + 2;
    localparam int MB   = DXW - 1;
    localparam int RB   = MB + 1;
    localparam int SB   = 2 * RB;
    localparam int KW   = ((F > MU_BITS) ? F : MU_BITS) + 1;
    localparam int UW   = F + 1;
    localparam int PW   = KW + UW;
    localparam int QT   = F + CAP_BITS;
    localparam int GW   = QT + 2;
    localparam int AW   = ((W + 3 > GW) ? W + 3 : GW) + 2;

    localparam logic signed [DXW-1:0] ONE_DX = DXW'(1) << F;
    localparam logic [KW-1:0]         ONE_K  = KW'(1) << F;
    localparam logic signed [AW-1:0]  SAT_HI = AW'((W'(1) << (W - 1)) - W'(1));
    localparam logic signed [AW-1:0]  SAT_LO = -SAT_HI - AW'(1);

    typedef struct packed {
        logic                  vld;
        logic [W-1:0]          x, y, z, vx, vy, vz;
    } t_inp;

    typedef struct packed {
        logic                  vld;
        logic [W-1:0]          x, y, vx, vy, vz;
        logic [MB-1:0]         m1, m2, my, mz;
        logic                  n1, n2, ny, nz;
        logic [SB-1:0]         s1, s2;
        logic                  z1, z2;
        logic [5:0]            capb;
    } t_ctx;

    typedef struct packed {
        logic                  vld;
        logic [W-1:0]          rx, ry, rz, ax, ay, az;
        logic                  sat;
    } t_res;

    logic               en;
    logic [MU_BITS-1:0] r_mu;
    t_inp               r_s0;
    t_ctx               r_c1, r_c2, r_c3, r_c6, r_c8;
    t_ctx               d_sq [RB];
    t_ctx               d_ud [UW];
    t_ctx               d_td [QT];
    t_ctx               c4, c5, c7, n_c1, n_c3, n_c6, n_c8;
    logic [2*MB-1:0]    r_sq1, r_sq2, r_sqy, r_sqz;
    logic [RB-1:0]      w_r1, w_r2;
    logic [UW-1:0]      w_u  [6];
    logic [MB-1:0]      w_um [6];
    logic [RB-1:0]      w_ud [6];
    logic [PW-1:0]      r_p  [6];
    logic [QT-1:0]      w_t  [6];
    logic [SB-1:0]      w_ts [6];
    logic [KW-1:0]      w_k1, w_k2;
    logic signed [GW-1:0] w_g [6];
    logic signed [AW-1:0] r_ax, r_ay, r_az;
    t_res               r_fin, r_out, r_skid, n_fin;
    logic               r_out_v, r_skid_v;

    assign en = !r_skid_v;
    assign o_s_axis_tready = en;

    // mass ratio register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= MU_RESET;
        end else if (i_cfg_wr_en) begin
            r_mu <= i_cfg_wr_data;
        end
    end

    // stage 0: capture input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else if (en) begin
            r_s0.vld <= i_s_axis_tvalid;
            r_s0.x   <= i_s_axis_tdata[0*W +: W];
            r_s0.y   <= i_s_axis_tdata[1*W +: W];
            r_s0.z   <= i_s_axis_tdata[2*W +: W];
            r_s0.vx  <= i_s_axis_tdata[3*W +: W];
            r_s0.vy  <= i_s_axis_tdata[4*W +: W];
            r_s0.vz  <= i_s_axis_tdata[5*W +: W];
        end
    end

    // stage 1: offsets to the primaries and magnitudes
    logic signed [DXW-1:0] w_xe, w_ye, w_ze, w_mue, w_dx1, w_dx2;
    always_comb begin
        w_xe  = DXW'($signed(r_s0.x));
        w_ye  = DXW'($signed(r_s0.y));
        w_ze  = DXW'($signed(r_s0.z));
        w_mue = DXW'($signed({1'b0, r_mu}));
        w_dx1 = w_xe + w_mue;
        w_dx2 = w_xe - ONE_DX + w_mue;
    end

    always_comb begin
        n_c1      = '0;
        n_c1.vld  = r_s0.vld;
        n_c1.x    = r_s0.x;
        n_c1.y    = r_s0.y;
        n_c1.vx   = r_s0.vx;
        n_c1.vy   = r_s0.vy;
        n_c1.vz   = r_s0.vz;
        n_c1.n1   = w_dx1[DXW-1];
        n_c1.n2   = w_dx2[DXW-1];
        n_c1.ny   = w_ye[DXW-1];
        n_c1.nz   = w_ze[DXW-1];
        n_c1.m1   = MB'(w_dx1[DXW-1] ? -w_dx1 : w_dx1);
        n_c1.m2   = MB'(w_dx2[DXW-1] ? -w_dx2 : w_dx2);
        n_c1.my   = MB'(w_ye[DXW-1] ? -w_ye : w_ye);
        n_c1.mz   = MB'(w_ze[DXW-1] ? -w_ze : w_ze);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
        end else if (en) begin
            r_c1 <= n_c1;
        end
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
        end else if (en) begin
            r_c2 <= r_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq1 <= r_c1.m1 * r_c1.m1;
            r_sq2 <= r_c1.m2 * r_c1.m2;
            r_sqy <= r_c1.my * r_c1.my;
            r_sqz <= r_c1.mz * r_c1.mz;
        end
    end

    // stage 3: squared distances
    logic [SB-1:0] w_s1, w_s2;
    always_comb begin
        w_s1 = SB'(r_sq1) + SB'(r_sqy) + SB'(r_sqz);
        w_s2 = SB'(r_sq2) + SB'(r_sqy) + SB'(r_sqz);
    end

    always_comb begin
        n_c3    = r_c2;
        n_c3.s1 = w_s1;
        n_c3.s2 = w_s2;
        n_c3.z1 = (w_s1 == '0);
        n_c3.z2 = (w_s2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3 <= '0;
        end else if (en) begin
            r_c3 <= n_c3;
        end
    end

    // square roots of both distances
    c3sd_isqrt #(.RB(RB)) u_sqrt1 (
        .i_clk(i_clk), .i_en(en), .i_rad(r_c3.s1), .o_root(w_r1)
    );
    c3sd_isqrt #(.RB(RB)) u_sqrt2 (
        .i_clk(i_clk), .i_en(en), .i_rad(r_c3.s2), .o_root(w_r2)
    );

    // context delay lines matching the unit latencies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < RB; j++) d_sq[j] <= '0;
            for (int j = 0; j < UW; j++) d_ud[j] <= '0;
            for (int j = 0; j < QT; j++) d_td[j] <= '0;
        end else if (en) begin
            d_sq[0] <= r_c3;
            for (int j = 1; j < RB; j++) d_sq[j] <= d_sq[j-1];
            d_ud[0] <= c4;
            for (int j = 1; j < UW; j++) d_ud[j] <= d_ud[j-1];
            d_td[0] <= n_c6;
            for (int j = 1; j < QT; j++) d_td[j] <= d_td[j-1];
        end
    end

    assign c4 = d_sq[RB-1];
    assign c5 = d_ud[UW-1];
    assign c7 = d_td[QT-1];

    // unit vector components c/r for all six terms
    always_comb begin
        w_um[0] = c4.m1;
        w_um[1] = c4.my;
        w_um[2] = c4.mz;
        w_um[3] = c4.m2;
        w_um[4] = c4.my;
        w_um[5] = c4.mz;
        for (int i = 0; i < 6; i++) begin
            w_ud[i] = (i < 3) ? w_r1 : w_r2;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < 6; gi++) begin : g_udiv
            c3sd_div #(.DW(RB), .QW(UW)) u_udiv (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (RB'(w_um[gi] >> 1)),
                .i_bits({w_um[gi][0], {F{1'b0}}}),
                .i_den (w_ud[gi]),
                .o_quo (w_u[gi])
            );
        end
    endgenerate

    // stage: scale by primary mass
    assign w_k1 = ONE_K - KW'(r_mu);
    assign w_k2 = KW'(r_mu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c6 <= '0;
        end else if (en) begin
            r_c6 <= c5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r_p[i] <= ((i < 3) ? w_k1 : w_k2) * w_u[i];
            end
        end
    end

    // term cap check rides with the context into the second divider chain
    always_comb begin
        n_c6 = r_c6;
        for (int i = 0; i < 6; i++) begin
            w_ts[i]      = (i < 3) ? r_c6.s1 : r_c6.s2;
            n_c6.capb[i] = ((SB + CAP_BITS)'(r_p[i]) >= {w_ts[i], {CAP_BITS{1'b0}}});
        end
    end

    generate
        for (gi = 0; gi < 6; gi++) begin : g_tdiv
            c3sd_div #(.DW(SB), .QW(QT)) u_tdiv (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (SB'(r_p[gi] >> CAP_BITS)),
                .i_bits({r_p[gi][CAP_BITS-1:0], {F{1'b0}}}),
                .i_den (w_ts[gi]),
                .o_quo (w_t[gi])
            );
        end
    endgenerate

    // signed gravity terms: zero on a primary, capped, or quotient
    logic [5:0] w_neg, w_zero, w_capm;
    always_comb begin
        w_neg  = {c7.nz, c7.ny, c7.n2, c7.nz, c7.ny, c7.n1};
        w_zero = {c7.z2, c7.z2, c7.z2, c7.z1, c7.z1, c7.z1};
        w_capm = c7.capb & ~w_zero;
        for (int i = 0; i < 6; i++) begin
            logic signed [GW-1:0] mg;
            mg = w_capm[i] ? (GW'(1) << QT) : GW'(w_t[i]);
            if (w_zero[i]) begin
                w_g[i] = '0;
            end else begin
                w_g[i] = w_neg[i] ? -mg : mg;
            end
        end
    end

    // stage: acceleration sums
    always_comb begin
        n_c8      = c7;
        n_c8.capb = w_capm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c8 <= '0;
        end else if (en) begin
            r_c8 <= n_c8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= (AW'($signed(c7.vy)) <<< 1) + AW'($signed(c7.x))
                    - AW'(w_g[0]) - AW'(w_g[3]);
            r_ay <= AW'($signed(c7.y)) - (AW'($signed(c7.vx)) <<< 1)
                    - AW'(w_g[1]) - AW'(w_g[4]);
            r_az <= -AW'(w_g[2]) - AW'(w_g[5]);
        end
    end

    // stage: saturation and flag
    always_comb begin
        logic sx, sy, sz;
        sx = (r_ax > SAT_HI) || (r_ax < SAT_LO);
        sy = (r_ay > SAT_HI) || (r_ay < SAT_LO);
        sz = (r_az > SAT_HI) || (r_az < SAT_LO);
        n_fin.vld = r_c8.vld;
        n_fin.rx  = r_c8.vx;
        n_fin.ry  = r_c8.vy;
        n_fin.rz  = r_c8.vz;
        n_fin.ax  = W'((r_ax > SAT_HI) ? SAT_HI : ((r_ax < SAT_LO) ? SAT_LO : r_ax));
        n_fin.ay  = W'((r_ay > SAT_HI) ? SAT_HI : ((r_ay < SAT_LO) ? SAT_LO : r_ay));
        n_fin.az  = W'((r_az > SAT_HI) ? SAT_HI : ((r_az < SAT_LO) ? SAT_LO : r_az));
        n_fin.sat = sx || sy || sz || r_c8.z1 || r_c8.z2 || (|r_c8.capb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= '0;
        end else if (en) begin
            r_fin <= n_fin;
        end
    end

    // output register with one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out    <= '0;
            r_skid   <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out    <= r_fin;
                r_out_v  <= r_fin.vld;
            end
        end else if (r_fin.vld && en) begin
            r_skid   <= r_fin;
            r_skid_v <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = TDW'({r_out.az, r_out.ay, r_out.ax, r_out.rz, r_out.ry, r_out.rx});
    assign o_m_axis_tuser  = r_out.sat;

    // the skid word only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word without output word");

    // a finished word meeting a blocked output must park in the skid register
    a_skid_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin.vld && !r_skid_v && r_out_v && !i_m_axis_tready) |=> r_skid_v)
        else $error("finished word lost at blocked output");

    // a state on a primary always raises the flag
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c8.vld && (r_c8.z1 || r_c8.z2)) |=> r_fin.sat)
        else $error("zero distance without saturation flag");
endmodule

FILE: dv/cr3bp_deriv_checker.sv
// Checker for the CR3BP state derivative core: watches the state, derivative and
// mass ratio ports, predicts each derivative word and compares it. Uses c3sd_pkg.
module cr3bp_deriv_checker
    import c3sd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_state_valid,
    input  logic                i_state_ready,
    input  logic [191:0]        i_state_data,
    input  logic                i_deriv_valid,
    input  logic                i_deriv_ready,
    input  logic [191:0]        i_deriv_data,
    input  logic                i_deriv_sat,
    input  logic                i_cfg_wr_en,
    input  logic [MU_BITS-1:0]  i_cfg_wr_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    localparam int FRAC = 27;

    typedef struct packed {
        logic [31:0] rate_x, rate_y, rate_z;
        logic [31:0] accel_x, accel_y, accel_z;
        logic        sat;
    } t_deriv;

    logic [MU_BITS-1:0] mass_ratio;
    t_deriv             deriv_q[$];

    // floor(sqrt(s)), bit pair at a time
    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s   = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // floor(num * 2^FRAC / den), long division with carry out of bit 63
    function automatic logic [63:0] scaled_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        logic        top;
        q = num / den;
        r = num % den;
        for (int i = 0; i < FRAC; i++) begin
            top = r[63];
            q   = q << 1;
            r   = r << 1;
            if (top || r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // k * c / r^3 for one component, capped at 2^(FRAC+CAP)
    function automatic longint pull(logic [63:0] k, longint c, logic [63:0] s,
                                    logic [63:0] r, inout bit flag);
        logic [63:0] u;
        logic [63:0] p;
        logic [63:0] t;
        u = (abs64(c) << FRAC) / r;
        p = k * u;
        if ((s >> (63 - CAP_BITS)) == 0 && p >= (s << CAP_BITS)) begin
            t    = 64'd1 << (FRAC + CAP_BITS);
            flag = 1'b1;
        end else begin
            t = scaled_div(p, s);
        end
        return c < 0 ? -longint'(t) : longint'(t);
    endfunction

    function automatic logic [31:0] clip32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_deriv state_derivative(logic [191:0] w, logic [MU_BITS-1:0] m);
        longint      x, y, z, vx, vy, vz, mu, one, dx1, dx2;
        logic [63:0] yz2, s1, s2, r1, r2, k1, k2;
        longint      g1x, g1y, g1z, g2x, g2y, g2z;
        bit          flag;
        t_deriv      d;
        x   = longint'($signed(w[31:0]));
        y   = longint'($signed(w[63:32]));
        z   = longint'($signed(w[95:64]));
        vx  = longint'($signed(w[127:96]));
        vy  = longint'($signed(w[159:128]));
        vz  = longint'($signed(w[191:160]));
        mu  = longint'({37'd0, m});
        one = 64'sd1 << FRAC;
        dx1 = x + mu;
        dx2 = x - one + mu;
        yz2 = abs64(y) * abs64(y) + abs64(z) * abs64(z);
        s1  = abs64(dx1) * abs64(dx1) + yz2;
        s2  = abs64(dx2) * abs64(dx2) + yz2;
        g1x = 0;
        g1y = 0;
        g1z = 0;
        g2x = 0;
        g2y = 0;
        g2z = 0;
        flag = 1'b0;
        // on a primary: its gravity drops out and the flag is set
        if (s1 == 0) begin
            flag = 1'b1;
        end else begin
            r1  = int_sqrt(s1);
            k1  = 64'(one - mu);
            g1x = pull(k1, dx1, s1, r1, flag);
            g1y = pull(k1, y, s1, r1, flag);
            g1z = pull(k1, z, s1, r1, flag);
        end
        if (s2 == 0) begin
            flag = 1'b1;
        end else begin
            r2  = int_sqrt(s2);
            k2  = 64'(mu);
            g2x = pull(k2, dx2, s2, r2, flag);
            g2y = pull(k2, y, s2, r2, flag);
            g2z = pull(k2, z, s2, r2, flag);
        end
        d.rate_x  = w[127:96];
        d.rate_y  = w[159:128];
        d.rate_z  = w[191:160];
        d.accel_x = clip32(2 * vy + x - g1x - g2x, flag);
        d.accel_y = clip32(-2 * vx + y - g1y - g2y, flag);
        d.accel_z = clip32(-g1z - g2z, flag);
        d.sat     = flag;
        return d;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        mass_ratio   = MU_RESET;
    end

    assign o_pending = deriv_q.size();

    // predict on accepted states, compare on accepted derivative words
    always @(posedge i_clk) begin
        t_deriv want;
        if (!i_rst_n) begin
            mass_ratio <= MU_RESET;
        end else begin
            if (i_cfg_wr_en) mass_ratio <= i_cfg_wr_data;
            if (i_state_valid && i_state_ready)
                deriv_q.push_back(state_derivative(i_state_data, mass_ratio));
            if (i_deriv_valid && i_deriv_ready) begin
                if (deriv_q.size() == 0) begin
                    $error("derivative word with no state waiting");
                    o_fail_count++;
                end else begin
                    want = deriv_q.pop_front();
                    check_field("rate_x", want.rate_x, i_deriv_data[31:0]);
                    check_field("rate_y", want.rate_y, i_deriv_data[63:32]);
                    check_field("rate_z", want.rate_z, i_deriv_data[95:64]);
                    check_field("accel_x", want.accel_x, i_deriv_data[127:96]);
                    check_field("accel_y", want.accel_y, i_deriv_data[159:128]);
                    check_field("accel_z", want.accel_z, i_deriv_data[191:160]);
                    check_field("saturated", {31'd0, want.sat}, {31'd0, i_deriv_sat});
                    o_checked++;
                end
            end
        end
    end
endmodule

FILE: dv/testbench.sv
// Top of the CR3BP state derivative testbench: clock, reset, stimulus, verdict.
// Depends on c3sd_pkg, cr3bp_state_derivative_core and cr3bp_deriv_checker.
module testbench;
    import c3sd_pkg::*;

    localparam int       LATENCY = 2 * 32 + 27 + 12 + 9;
    localparam int       ONE     = 1 << 27;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [191:0]        s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [191:0]        m_data;
    logic                m_user;
    logic                cfg_en = 1'b0;
    logic [MU_BITS-1:0]  cfg_data = '0;
    int                  fail_count, pending, checked;
    int                  settings;
    logic [MU_BITS-1:0]  mu;
    bit                  quiet;

    cr3bp_state_derivative_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data)
    );

    cr3bp_deriv_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_state_valid (s_valid),
        .i_state_ready (s_ready),
        .i_state_data  (s_data),
        .i_deriv_valid (m_valid),
        .i_deriv_ready (m_ready),
        .i_deriv_data  (m_data),
        .i_deriv_sat   (m_user),
        .i_cfg_wr_en   (cfg_en),
        .i_cfg_wr_data (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("cr3bp_state_derivative_core: mismatch");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // derivative side back-pressure
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                m_ready = 1'b0;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                m_ready = $urandom_range(0, 2) != 0;
                hold    = gap_len();
            end
        end
    end

    task automatic send_state(logic [31:0] x, y, z, vx, vy, vz);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {vz, vy, vx, z, y, x};
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    task automatic set_mass(logic [MU_BITS-1:0] v);
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 8) @(negedge i_clk);
        cfg_en   = 1'b1;
        cfg_data = v;
        mu       = v;
        @(negedge i_clk);
        cfg_en = 1'b0;
        settings++;
    endtask

    function automatic logic [31:0] near(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // scaled position/velocity, the way an orbit propagator would feed it
    function automatic logic [31:0] orbit_val(int scale);
        return near(scale) <<< $urandom_range(0, 3);
    endfunction

    task automatic random_states(int n);
        int          kind, sh;
        logic [31:0] cx;
        repeat (n) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                send_state(orbit_val(ONE / 4), orbit_val(ONE / 4), orbit_val(ONE / 8),
                           orbit_val(ONE / 8), orbit_val(ONE / 8), orbit_val(ONE / 8));
            end else if (kind < 75) begin
                // close pass by one primary
                cx = $urandom_range(0, 1) ? 32'(ONE) - 32'(mu) : -32'(mu);
                sh = $urandom_range(0, 26);
                send_state(cx + near(1 << sh), near(1 << sh), near(1 << sh),
                           $urandom, $urandom, $urandom);
            end else begin
                send_state($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic primaries();
        send_state(-32'(mu), 0, 0, 0, 0, 0);
        send_state(32'(ONE) - 32'(mu), 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_state(-32'(mu) + 1, 0, 0, 0, 0, 0);
        send_state(32'(ONE) - 32'(mu), 0, 1, 0, 0, 0);
    endtask

    initial begin
        logic [MU_BITS-1:0] mu_list [5];
        settings = 1;
        mu       = MU_RESET;
        quiet    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed states at the reset mass ratio
        quiet = 1'b1;
        send_state(0, 0, 0, 0, 0, 0);
        primaries();
        send_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_state(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_state(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
        send_state(32'h0d5f_4c80, 0, 0, 0, 0, 0);
        send_state(32'h0800_0000, 32'h0400_0000, 32'hfc00_0000, 32'h0100_0000, 1, -1);
        send_state(1, 1, 1, 1, 1, 1);
        send_state(-1, -1, -1, -1, -1, -1);
        send_state(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                   32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        quiet = 1'b0;
        random_states(150);

        // mass ratio sweep: zero, one half, top of the register, small, random
        mu_list = '{27'd0, 27'd67108864, 27'h7ff_ffff, 27'd1215058, 27'($urandom)};
        foreach (mu_list[i]) begin
            set_mass(mu_list[i]);
            quiet = 1'b1;
            primaries();
            random_states(40);
            quiet = 1'b0;
            random_states(100);
        end

        s_valid = 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("checked %0d derivative words across %0d mass ratio settings,",
                 checked, settings);
        $display("including both primaries, close passes and full-range states");
        if (fail_count == 0)
            $display("cr3bp_state_derivative_core: match");
        else
            $display("cr3bp_state_derivative_core: mismatch");
        $finish;
    end
endmodule
